// ===== rtl/simple16_packed_word_decoder_macros.svh =====
// assertion helpers for the simple-16 word decoder
`ifndef SIMPLE16_PACKED_WORD_DECODER_MACROS_SVH
`define SIMPLE16_PACKED_WORD_DECODER_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define S16D_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("s16d check failed");
// next-cycle implication
`define S16D_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("s16d check failed");
`else
`define S16D_ASSERT(lbl, ante, cons)
`define S16D_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/s16d_pkg.sv =====
package s16d_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned ValueW = 28;
  localparam int unsigned SelW   = 4;
  localparam int unsigned IdxW   = 5;
  localparam int unsigned TotalW = 32;

  localparam logic [TotalW-1:0] TotalMax = 32'hFFFF_FFFF;

  // per layout: end of first run, end of second run, item count, run widths
  localparam logic [IdxW-1:0] RunEnd1 [16] =
    '{5'd28, 5'd7, 5'd7, 5'd14, 5'd14, 5'd1, 5'd1, 5'd7,
      5'd4, 5'd2, 5'd3, 5'd2, 5'd4, 5'd1, 5'd2, 5'd1};
  localparam logic [IdxW-1:0] RunEnd2 [16] =
    '{5'd28, 5'd21, 5'd14, 5'd21, 5'd14, 5'd9, 5'd5, 5'd7,
      5'd6, 5'd6, 5'd5, 5'd5, 5'd4, 5'd3, 5'd2, 5'd1};
  localparam logic [IdxW-1:0] ItemCount [16] =
    '{5'd28, 5'd21, 5'd21, 5'd21, 5'd14, 5'd9, 5'd8, 5'd7,
      5'd6, 5'd6, 5'd5, 5'd5, 5'd4, 5'd3, 5'd2, 5'd1};
  localparam logic [IdxW-1:0] RunW0 [16] =
    '{5'd1, 5'd2, 5'd1, 5'd1, 5'd2, 5'd4, 5'd3, 5'd4,
      5'd5, 5'd4, 5'd6, 5'd5, 5'd7, 5'd10, 5'd14, 5'd28};
  localparam logic [IdxW-1:0] RunW1 [16] =
    '{5'd1, 5'd1, 5'd2, 5'd2, 5'd2, 5'd3, 5'd4, 5'd4,
      5'd4, 5'd5, 5'd5, 5'd6, 5'd7, 5'd9, 5'd14, 5'd28};
  localparam logic [IdxW-1:0] RunW2 [16] =
    '{5'd1, 5'd1, 5'd1, 5'd2, 5'd2, 5'd3, 5'd3, 5'd4,
      5'd4, 5'd5, 5'd5, 5'd6, 5'd7, 5'd9, 5'd14, 5'd28};

  typedef struct packed {
    logic              valid;
    logic [ValueW-1:0] value;
    logic              last;
  } elem_t;

  function automatic logic [IdxW-1:0] field_width(input logic [SelW-1:0] sel,
                                                  input logic [IdxW-1:0] idx);
    logic [IdxW-1:0] w;
    if (idx < RunEnd1[sel]) begin
      w = RunW0[sel];
    end else if (idx < RunEnd2[sel]) begin
      w = RunW1[sel];
    end else begin
      w = RunW2[sel];
    end
    return w;
  endfunction

endpackage

// ===== rtl/s16d_unpack.sv =====
module s16d_unpack (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             load_i,
  input  logic [s16d_pkg::WordW-1:0]       word_i,
  input  logic                             advance_i,
  output s16d_pkg::elem_t                  elem_o
);

  logic                            act_q, act_d;
  logic [s16d_pkg::WordW-1:0]      word_q, word_d;
  logic [s16d_pkg::IdxW-1:0]       idx_q, idx_d;
  logic [s16d_pkg::IdxW-1:0]       shift_q, shift_d;

  logic [s16d_pkg::SelW-1:0]       sel;
  logic [s16d_pkg::ValueW-1:0]     payload;
  logic [s16d_pkg::IdxW-1:0]       width;
  logic [s16d_pkg::ValueW-1:0]     mask;
  logic                            last;

  assign sel     = word_q[s16d_pkg::SelW-1:0];
  assign payload = word_q[s16d_pkg::WordW-1:s16d_pkg::SelW];
  assign width   = s16d_pkg::field_width(sel, idx_q);
  // width is at least one, so the shift stays below the value width
  assign mask    = {s16d_pkg::ValueW{1'b1}} >> (5'd28 - width);
  assign last    = (idx_q == (s16d_pkg::ItemCount[sel] - 5'd1));

  assign elem_o.valid = act_q;
  assign elem_o.value = (payload >> shift_q) & mask;
  assign elem_o.last  = last;

  always_comb begin
    act_d   = act_q;
    word_d  = word_q;
    idx_d   = idx_q;
    shift_d = shift_q;
    if (advance_i) begin
      if (last) begin
        act_d = 1'b0;
      end else begin
        idx_d   = idx_q + 5'd1;
        shift_d = shift_q + width;
      end
    end
    if (load_i) begin
      act_d   = 1'b1;
      word_d  = word_i;
      idx_d   = '0;
      shift_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q   <= 1'b0;
      idx_q   <= '0;
      shift_q <= '0;
    end else begin
      act_q   <= act_d;
      idx_q   <= idx_d;
      shift_q <= shift_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

endmodule

// ===== rtl/s16d_tally.sv =====
module s16d_tally (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [s16d_pkg::TotalW-1:0]  cfg_wdata_i,
  input  logic                         emit_i,
  output logic                         done_o
);

  logic [s16d_pkg::TotalW-1:0] count_q;
  logic [s16d_pkg::TotalW-1:0] total_q, total_d;

  // saturating count of integers handed to the output
  always_comb begin
    total_d = total_q;
    if (emit_i && (total_q != s16d_pkg::TotalMax)) begin
      total_d = total_q + 32'd1;
    end
  end

  // covers both the flag of the item being emitted and the drop check
  assign done_o = (total_d >= count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      total_q <= '0;
    end else begin
      total_q <= total_d;
      if (cfg_we_i) begin
        count_q <= cfg_wdata_i;
      end
    end
  end

endmodule

// ===== rtl/simple16_packed_word_decoder.sv =====
// Simple-16 word decoder. Each accepted packed_word_i is unpacked into 1 to 28
// integers, least significant field first, one integer per cycle on the output
// channel unless out_ready_i stalls it; last_of_word_o marks the final one and
// stream_done_o shows that the running count has reached the value written to
// cfg_wdata_i. A word holds the unpacker until its final integer, their number
// set by its layout selector; the next word is taken in the cycle the final
// integer moves into the output register, so the output port runs without gaps.
// Words that arrive once the count is reached are accepted and dropped.
`include "simple16_packed_word_decoder_macros.svh"

module simple16_packed_word_decoder (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [s16d_pkg::TotalW-1:0]    cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [s16d_pkg::WordW-1:0]     packed_word_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [s16d_pkg::ValueW-1:0]    decoded_value_o,
  output logic                           last_of_word_o,
  output logic                           stream_done_o
);

  s16d_pkg::elem_t elem;

  logic out_free;
  logic emit;
  logic accept;
  logic load;
  logic done_now;

  logic                          out_valid_q;
  logic [s16d_pkg::ValueW-1:0]   value_q;
  logic                          last_q;
  logic                          done_q;

  assign out_free   = !out_valid_q || out_ready_i;
  assign emit       = elem.valid && out_free;
  assign in_ready_o = !elem.valid || (emit && elem.last);
  assign accept     = in_valid_i && in_ready_o;
  assign load       = accept && !done_now;

  s16d_unpack u_unpack (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (load),
    .word_i    (packed_word_i),
    .advance_i (emit),
    .elem_o    (elem)
  );

  s16d_tally u_tally (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .emit_i      (emit),
    .done_o      (done_now)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      value_q <= elem.value;
      last_q  <= elem.last;
      done_q  <= done_now;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign decoded_value_o = value_q;
  assign last_of_word_o  = last_q;
  assign stream_done_o   = done_q;

  // a dropped word never reaches the unpacker
  `S16D_ASSERT_NXT(a_drop_idle, accept && done_now, !elem.valid)
  // an item waiting at the output is never overwritten
  `S16D_ASSERT(a_no_overwrite, out_valid_o && !out_ready_i, !emit)
  // every emitted integer shows up at the output
  `S16D_ASSERT_NXT(a_emit_shows, emit, out_valid_o)

endmodule

// ===== sim/testbench.sv =====
module testbench;
  localparam int unsigned WordW  = s16d_pkg::WordW;
  localparam int unsigned ValueW = s16d_pkg::ValueW;
  localparam int unsigned TotalW = s16d_pkg::TotalW;
  localparam logic [TotalW-1:0] TotalMax = s16d_pkg::TotalMax;

  // layout selectors, named after their (count x width) runs
  localparam logic [3:0] Lay28x1        = 4'd0;
  localparam logic [3:0] Lay7x2_14x1    = 4'd1;
  localparam logic [3:0] Lay7x1_7x2_7x1 = 4'd2;
  localparam logic [3:0] Lay14x1_7x2    = 4'd3;
  localparam logic [3:0] Lay14x2        = 4'd4;
  localparam logic [3:0] Lay1x4_8x3     = 4'd5;
  localparam logic [3:0] Lay1x3_4x4_3x3 = 4'd6;
  localparam logic [3:0] Lay7x4         = 4'd7;
  localparam logic [3:0] Lay4x5_2x4     = 4'd8;
  localparam logic [3:0] Lay2x4_4x5     = 4'd9;
  localparam logic [3:0] Lay3x6_2x5     = 4'd10;
  localparam logic [3:0] Lay2x5_3x6     = 4'd11;
  localparam logic [3:0] Lay4x7         = 4'd12;
  localparam logic [3:0] Lay1x10_2x9    = 4'd13;
  localparam logic [3:0] Lay2x14        = 4'd14;
  localparam logic [3:0] Lay1x28        = 4'd15;

  localparam int ResetCycles   = 12;
  localparam int DrainPause    = 8;
  localparam int LongHold      = 400;
  localparam int WatchdogLimit = 3000;
  localparam int RandomWords   = 180;
  localparam int MaxReports    = 10;

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic              last;
    logic              done;
  } decoded_int_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [TotalW-1:0] cfg_wdata;
  logic              in_valid;
  logic              in_ready;
  logic [WordW-1:0]  packed_word;
  logic              out_valid;
  logic              out_ready;
  logic [ValueW-1:0] out_value;
  logic              out_last;
  logic              out_done;

  // predictor state
  logic [TotalW-1:0] count_limit = '0;
  logic [TotalW-1:0] ints_emitted = '0;
  decoded_int_t      pending_ints[$];

  bit in_gaps_on    = 1'b0;
  bit out_stalls_on = 1'b0;
  bit long_hold_req = 1'b0;

  int mismatches       = 0;
  int integers_checked = 0;
  int words_decoded    = 0;
  int words_dropped    = 0;

  simple16_packed_word_decoder i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .packed_word_i  (packed_word),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .decoded_value_o(out_value),
    .last_of_word_o (out_last),
    .stream_done_o  (out_done)
  );

  always #10 clk = ~clk;

  // runs packed as {run2, run1, run0}, each run {count[4:0], width[4:0]}
  function automatic logic [29:0] layout_of(input logic [3:0] sel);
    logic [29:0] runs;
    case (sel)
      Lay28x1:        runs = {10'd0, 10'd0, 5'd28, 5'd1};
      Lay7x2_14x1:    runs = {10'd0, 5'd14, 5'd1, 5'd7, 5'd2};
      Lay7x1_7x2_7x1: runs = {5'd7, 5'd1, 5'd7, 5'd2, 5'd7, 5'd1};
      Lay14x1_7x2:    runs = {10'd0, 5'd7, 5'd2, 5'd14, 5'd1};
      Lay14x2:        runs = {10'd0, 10'd0, 5'd14, 5'd2};
      Lay1x4_8x3:     runs = {10'd0, 5'd8, 5'd3, 5'd1, 5'd4};
      Lay1x3_4x4_3x3: runs = {5'd3, 5'd3, 5'd4, 5'd4, 5'd1, 5'd3};
      Lay7x4:         runs = {10'd0, 10'd0, 5'd7, 5'd4};
      Lay4x5_2x4:     runs = {10'd0, 5'd2, 5'd4, 5'd4, 5'd5};
      Lay2x4_4x5:     runs = {10'd0, 5'd4, 5'd5, 5'd2, 5'd4};
      Lay3x6_2x5:     runs = {10'd0, 5'd2, 5'd5, 5'd3, 5'd6};
      Lay2x5_3x6:     runs = {10'd0, 5'd3, 5'd6, 5'd2, 5'd5};
      Lay4x7:         runs = {10'd0, 10'd0, 5'd4, 5'd7};
      Lay1x10_2x9:    runs = {10'd0, 5'd2, 5'd9, 5'd1, 5'd10};
      Lay2x14:        runs = {10'd0, 10'd0, 5'd2, 5'd14};
      Lay1x28:        runs = {10'd0, 10'd0, 5'd1, 5'd28};
      default:        runs = '0;
    endcase
    return runs;
  endfunction

  // queues the integers one accepted word must produce, returns how many
  function automatic int unpack_word(input logic [WordW-1:0] word);
    logic [29:0]       runs;
    logic [27:0]       payload;
    logic [ValueW-1:0] mask;
    decoded_int_t      item;
    int                per_word;
    int                emitted;
    int                shift;
    int                cnt;
    int                wid;
    if (ints_emitted >= count_limit) return 0;
    runs = layout_of(word[3:0]);
    payload = word[31:4];
    per_word = 0;
    for (int r = 0; r < 3; r++) per_word += int'(runs[r*10+5 +: 5]);
    emitted = 0;
    shift = 0;
    for (int r = 0; r < 3; r++) begin
      cnt = int'(runs[r*10+5 +: 5]);
      wid = int'(runs[r*10 +: 5]);
      mask = (ValueW'(1) << wid) - ValueW'(1);
      for (int k = 0; k < cnt; k++) begin
        item.value = (payload >> shift) & mask;
        if (ints_emitted != TotalMax) ints_emitted++;
        item.last = (emitted + 1 == per_word);
        item.done = (ints_emitted >= count_limit);
        pending_ints.push_back(item);
        emitted++;
        shift += wid;
      end
    end
    return emitted;
  endfunction

  function automatic logic [WordW-1:0] random_word();
    logic [27:0] payload;
    case ($urandom_range(0, 3))
      0:       payload = '1;
      1:       payload = '0;
      default: payload = 28'($urandom);
    endcase
    return {payload, 4'($urandom_range(0, 15))};
  endfunction

  function automatic void note_mismatch(input string what);
    mismatches++;
    if (mismatches <= MaxReports) $display("mismatch: %s", what);
  endfunction

  task automatic send_word(input logic [WordW-1:0] word, output int produced);
    int gap;
    gap = 0;
    if (in_gaps_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 12);
    repeat (gap) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid = 1'b1;
    packed_word = word;
    do begin
      @(posedge clk);
    end while (!in_ready);
    produced = unpack_word(word);
    if (produced == 0) words_dropped++;
    else words_decoded++;
  endtask

  task automatic park_sender();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_ints.size() != 0) @(posedge clk);
    // dropped words leave no trace, so wait a further DrainPause before returning
    repeat (DrainPause) @(posedge clk);
  endtask

  task automatic set_integer_count(input logic [TotalW-1:0] value);
    wait_drained();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    count_limit = value;
  endtask

  task automatic test_zero_count_after_reset();
    int produced;
    for (int i = 0; i < 3; i++) send_word(random_word(), produced);
    park_sender();
  endtask

  task automatic test_every_layout();
    int produced;
    set_integer_count(TotalMax);
    for (int s = 0; s < 16; s++) send_word({28'hFFF_FFFF, 4'(s)}, produced);
    send_word({28'h000_0000, Lay28x1}, produced);
    park_sender();
  endtask

  task automatic test_total_crossing();
    int produced;
    // a 28-integer word that runs past the total, then the stream is closed
    set_integer_count(ints_emitted + 5);
    send_word({28'hFFF_FFFF, Lay28x1}, produced);
    send_word({28'hA5A_5A5A, Lay7x4}, produced);
    send_word({28'h5A5_A5A5, Lay1x28}, produced);
    park_sender();
    // reopen by one integer: total reached exactly on a single-integer word
    set_integer_count(ints_emitted + 1);
    send_word({28'h800_0001, Lay1x28}, produced);
    send_word({28'h123_4567, Lay2x14}, produced);
    park_sender();
    // limit lowered below the count already decoded
    set_integer_count(ints_emitted - 7);
    send_word({28'hFFF_FFFF, Lay14x2}, produced);
    park_sender();
  endtask

  task automatic test_output_hold();
    int produced;
    set_integer_count(TotalMax);
    in_gaps_on = 1'b0;
    long_hold_req = 1'b1;
    for (int i = 0; i < 20; i++) send_word(random_word(), produced);
    park_sender();
  endtask

  task automatic test_random_streams();
    logic [TotalW-1:0] limit;
    int                goal;
    int                phase_words;
    int                drops;
    int                produced;
    in_gaps_on = 1'b1;
    out_stalls_on = 1'b1;
    goal = words_decoded + RandomWords;
    while (words_decoded < goal) begin
      if ($urandom_range(0, 5) == 0) limit = TotalMax;
      else limit = ints_emitted + $urandom_range(1, 300);
      set_integer_count(limit);
      phase_words = 0;
      drops = 0;
      while (phase_words < 60 && drops < 2) begin
        send_word(random_word(), produced);
        phase_words++;
        if (produced == 0) drops++;
      end
      park_sender();
    end
  endtask

  task automatic test_back_to_back();
    int produced;
    in_gaps_on = 1'b0;
    out_stalls_on = 1'b0;
    set_integer_count(TotalMax);
    for (int i = 0; i < 30; i++) send_word(random_word(), produced);
    park_sender();
    set_integer_count('0);
    for (int i = 0; i < 3; i++) send_word(random_word(), produced);
    park_sender();
  endtask

  always @(posedge clk) begin : check_outputs
    decoded_int_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_ints.size() == 0) begin
        note_mismatch($sformatf("unexpected item: value %h last %b done %b",
                                out_value, out_last, out_done));
      end else begin
        want = pending_ints.pop_front();
        integers_checked++;
        if (out_value !== want.value || out_last !== want.last ||
            out_done !== want.done) begin
          note_mismatch($sformatf(
            "integer %0d: expected value %h last %b done %b, got %h %b %b",
            integers_checked, want.value, want.last, want.done,
            out_value, out_last, out_done));
        end
      end
    end
  end

  initial begin : receiver
    int hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else if (long_hold_req) begin
        out_ready = 1'b0;
        hold_left = LongHold - 1;
        long_hold_req = 1'b0;
      end else if (out_stalls_on && $urandom_range(0, 7) == 0) begin
        out_ready = 1'b0;
        hold_left = $urandom_range(0, 11);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WatchdogLimit) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("watchdog: no item moved for %0d cycles", WatchdogLimit);
    $display("FAILURE");
    $finish;
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    packed_word = '0;
    repeat (ResetCycles) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    in_gaps_on = 1'b1;
    out_stalls_on = 1'b1;
    test_zero_count_after_reset();
    test_every_layout();
    test_total_crossing();
    test_output_hold();
    test_random_streams();
    test_back_to_back();

    wait_drained();
    repeat (20) @(posedge clk);
    if (pending_ints.size() != 0) begin
      note_mismatch($sformatf("%0d integers never arrived", pending_ints.size()));
    end
    $display("run covered %0d decoded and %0d dropped words, %0d integers checked",
             words_decoded, words_dropped, integers_checked);
    $display("all 16 layouts, limit crossing, zero and full limits, long output hold");
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== simple16_packed_word_decoder.f =====
+incdir+rtl
rtl/s16d_pkg.sv
rtl/s16d_unpack.sv
rtl/s16d_tally.sv
rtl/simple16_packed_word_decoder.sv
sim/testbench.sv
